FILE: sv/binary_morphology_window_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the binary morphology window core
// Concurrent checks clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_MORPHOLOGY_WINDOW_CORE_DEFINES_SVH
`define BINARY_MORPHOLOGY_WINDOW_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BMW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define BMW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define BMW_ASSERT(lbl, prop, msg)
`define BMW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

FILE: sv/bmw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_pkg
// Operation codes, register indexes and shared types of the morphology core.
// ----------------------------------------------------------------------------
package bmw_pkg;

	typedef enum logic [1:0] {
		OP_ERODE   = 2'd0,
		OP_DILATE  = 2'd1,
		OP_OPENING = 2'd2,
		OP_CLOSING = 2'd3
	} bmw_op_t;

	localparam logic [2:0] CFG_OP_MODE    = 3'd0;
	localparam logic [2:0] CFG_RADIUS     = 3'd1;
	localparam logic [2:0] CFG_WIDTH      = 3'd2;
	localparam logic [2:0] CFG_HEIGHT     = 3'd3;
	localparam logic [2:0] CFG_MASK       = 3'd4;
	localparam logic [2:0] CFG_BACKGROUND = 3'd5;
	localparam logic [2:0] CFG_FOREGROUND = 3'd6;

	localparam int CFG_DATA_BITS = 49;
	localparam int RAD_BITS      = 2;
	localparam int MASK_RAD      = 3;
	localparam int MASK_SIDE     = 7;
	localparam int MASK_BITS     = MASK_SIDE * MASK_SIDE;

	// per-pass operating mode
	typedef struct packed {
		logic                dilate;
		logic                err;
		logic [RAD_BITS-1:0] rad;
	} bmw_mode_t;

	// status of one item leaving a pass
	typedef struct packed {
		logic vld;
		logic inframe;
		logic last;
		logic first;
	} bmw_flags_t;

endpackage

FILE: sv/bmw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmw_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module bmw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: sv/bmw_stage.sv
`timescale 1ns / 1ps
`include "binary_morphology_window_core_defines.svh"
// ----------------------------------------------------------------------------
// bmw_stage
// One erode or dilate pass: line RAM, window registers and a parallel test.
// ----------------------------------------------------------------------------
module bmw_stage #(
	parameter int RAD        = 3,
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8,
	parameter int POS_BITS   = 28
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  logic [PIXEL_BITS-1:0]              in_val,
	input  logic                               in_start,
	input  bmw_pkg::bmw_mode_t                 mode,
	input  logic [$clog2(MAX_WIDTH):0]         w_eff,
	input  logic [15:0]                        h_eff,
	input  logic [$clog2(MAX_WIDTH)+2:0]       win_delay,
	input  logic [PIXEL_BITS-1:0]              bg,
	input  logic [PIXEL_BITS-1:0]              fg,
	input  logic [(2*RAD+1)*(2*RAD+1)-1:0]     emask,
	output bmw_pkg::bmw_flags_t                out_flags,
	output logic [PIXEL_BITS-1:0]              out_val
);
	import bmw_pkg::*;

	localparam int N  = 2 * RAD + 1;
	localparam int CB = $clog2(MAX_WIDTH);
	localparam int LW = 2 * RAD * PIXEL_BITS;
	localparam int IW = $clog2(N);
	localparam int PB = PIXEL_BITS;

	logic [POS_BITS-1:0] p_q, p_eff;
	logic [CB-1:0]       col_q, col_eff, cx_q, cx_eff;
	logic [15:0]         cy_q, cy_eff;
	logic                act, first_a, col_wrap, cx_wrap;

	logic                vld_s1, act_s1, first_s1, byp_s1;
	logic [PB-1:0]       val_s1;
	logic [CB-1:0]       col_s1, cx_s1;
	logic [15:0]         cy_s1;
	logic [LW-1:0]       bypw_s1, rdata, rd_use, wword;

	logic                vld_s2, first_s2;
	logic [CB-1:0]       cx_s2;
	logic [15:0]         cy_s2;

	logic [PB-1:0]       win_q [N][N];
	logic [PB-1:0]       colv [N];
	logic [IW-1:0]       cidx;
	logic [PB-1:0]       ctr, res;
	logic [N-1:0]        row_ok, col_ok;
	logic                hit, inframe, last;

	bmw_flags_t          flags_s3;
	logic [PB-1:0]       val_s3;

	// position and center counters at the input
	always_comb begin
		p_eff    = in_start ? '0 : p_q;
		col_eff  = in_start ? '0 : col_q;
		cx_eff   = in_start ? '0 : cx_q;
		cy_eff   = in_start ? '0 : cy_q;
		act      = p_eff >= POS_BITS'(win_delay);
		first_a  = p_eff == POS_BITS'(win_delay);
		col_wrap = {1'b0, col_eff} == (w_eff - 1'b1);
		cx_wrap  = {1'b0, cx_eff} == (w_eff - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q    <= '0;
			col_q  <= '0;
			cx_q   <= '0;
			cy_q   <= '0;
			vld_s1 <= 1'b0;
			byp_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			if (in_vld) begin
				p_q   <= (p_eff == '1) ? p_eff : p_eff + 1'b1;
				col_q <= col_wrap ? '0 : col_eff + 1'b1;
				if (act) begin
					cx_q <= cx_wrap ? '0 : cx_eff + 1'b1;
					cy_q <= (cx_wrap && cy_eff != '1) ? cy_eff + 1'b1 : cy_eff;
				end else begin
					cx_q <= cx_eff;
					cy_q <= cy_eff;
				end
			end
			vld_s1 <= in_vld;
			// forward the word written in the same cycle as the read
			byp_s1 <= vld_s1 && (col_s1 == col_eff);
			vld_s2 <= vld_s1 && act_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s1   <= in_val;
			col_s1   <= col_eff;
			act_s1   <= act;
			first_s1 <= first_a;
			cx_s1    <= cx_eff;
			cy_s1    <= cy_eff;
			bypw_s1  <= wword;
			first_s2 <= first_s1;
			cx_s2    <= cx_s1;
			cy_s2    <= cy_s1;
		end
	end

	bmw_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_WIDTH)
	) u_line (
		.clk   (clk),
		.we    (en && vld_s1),
		.waddr (col_s1),
		.wdata (wword),
		.re    (en),
		.raddr (col_eff),
		.rdata (rdata)
	);

	// column of the newest pixel and the rows above it
	always_comb begin
		rd_use = byp_s1 ? bypw_s1 : rdata;
		colv[0] = val_s1;
		for (int j = 1; j < N; j++) begin
			colv[j] = rd_use[(j-1)*PB +: PB];
		end
		wword[PB-1:0] = val_s1;
		for (int m = 1; m < 2 * RAD; m++) begin
			wword[m*PB +: PB] = rd_use[(m-1)*PB +: PB];
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_s1) begin
			for (int j = 0; j < N; j++) begin
				for (int k = 0; k < N; k++) begin
					if (k == 0) begin
						win_q[j][k] <= colv[j];
					end else begin
						win_q[j][k] <= win_q[j][k-1];
					end
				end
			end
		end
	end

	// parallel window test
	always_comb begin
		int ny;
		int nx;
		cidx = IW'(mode.rad);
		ctr  = win_q[cidx][cidx];
		for (int j = 0; j < N; j++) begin
			ny = int'(cy_s2) + int'(mode.rad) - j;
			row_ok[j] = (ny >= 0) && (ny < int'(h_eff));
			nx = int'(cx_s2) + int'(mode.rad) - j;
			col_ok[j] = (nx >= 0) && (nx < int'(w_eff));
		end
		hit = 1'b0;
		for (int j = 0; j < N; j++) begin
			for (int k = 0; k < N; k++) begin
				if (emask[j*N+k] && row_ok[j] && col_ok[k]) begin
					if (mode.dilate ? (win_q[j][k] != bg) : (win_q[j][k] == bg)) begin
						hit = 1'b1;
					end
				end
			end
		end
		if (mode.err) begin
			res = ctr;
		end else if (mode.dilate) begin
			res = (ctr == bg && hit) ? fg : ctr;
		end else begin
			res = (ctr != bg && hit) ? bg : ctr;
		end
		inframe = cy_s2 < h_eff;
		last    = ({1'b0, cx_s2} == (w_eff - 1'b1)) && (cy_s2 == h_eff - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flags_s3 <= '0;
		end else if (en) begin
			flags_s3.vld     <= vld_s2;
			flags_s3.inframe <= vld_s2 && inframe;
			flags_s3.last    <= vld_s2 && inframe && last;
			flags_s3.first   <= vld_s2 && first_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			val_s3 <= inframe ? res : bg;
		end
	end

	assign out_flags = flags_s3;
	assign out_val   = val_s3;

	`BMW_ASSERT(a_last_in_frame, !flags_s3.last || flags_s3.inframe, "last outside frame")
	`BMW_ASSERT(a_first_valid, !flags_s3.first || flags_s3.vld, "first on empty slot")
	`BMW_ASSERT_NEXT(a_stall_hold, !en, $stable(flags_s3), "result moved during stall")
endmodule

FILE: sv/binary_morphology_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_morphology_window_core
// Streaming binary erosion, dilation, opening and closing on raster pixels.
// ----------------------------------------------------------------------------
// Takes one pixel or flush item per clock and gives at most one result per
// item. Each pass (one for erode and dilate, two in cascade for opening and
// closing) emits the result for raster position p when the item at p + D is
// accepted, D = radius * image_width + radius, and adds three register stages
// (input register, window shift, result register). The line RAM of each pass
// (MAX_WIDTH deep, one write and one read per clock) and the window registers
// hold the rows the window needs; the whole window is tested at once by combinational logic.
// The core stalls only while a result waits to be taken at the output.
module binary_morphology_window_core #(
	parameter int MAX_RADIUS = 3,
	parameter int MAX_WIDTH  = 1024,
	parameter int PIXEL_BITS = 8
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [((PIXEL_BITS+7)/8)*8-1:0]        s_tdata,     // pixel_in
	input  logic [1:0]                             s_tuser,     // is_flush, frame_start
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [((PIXEL_BITS+7)/8)*8-1:0]        m_tdata,     // pixel_out
	output logic                                   m_tlast,
	output logic [0:0]                             m_tuser,     // size_error
	input  logic                                   cfg_wr_en,
	input  logic [2:0]                             cfg_index,
	input  logic [bmw_pkg::CFG_DATA_BITS-1:0]      cfg_wr_data
);
	import bmw_pkg::*;

	localparam int RAD      = (MAX_RADIUS < MASK_RAD) ? MAX_RADIUS : MASK_RAD;
	localparam int N        = 2 * RAD + 1;
	localparam int CB       = $clog2(MAX_WIDTH);
	localparam int DB       = CB + 3;
	localparam int POS_BITS = CB + 18;
	localparam int TDW      = ((PIXEL_BITS + 7) / 8) * 8;
	localparam int PB       = PIXEL_BITS;

	bmw_op_t              op_mode_q;
	logic [RAD_BITS-1:0]  radius_q;
	logic [10:0]          width_q;
	logic [15:0]          height_q;
	logic [MASK_BITS-1:0] mask_q;
	logic [7:0]           bg_q, fg_q;

	logic [RAD_BITS-1:0]  rad_c;
	logic [CB:0]          w_c;
	logic [15:0]          h_c;
	logic [DB-1:0]        d_c;
	logic                 err_c, two_c;
	logic [N*N-1:0]       emask_c;
	logic [PB-1:0]        bg_c, fg_c;
	bmw_mode_t            mode1, mode2;

	bmw_flags_t           f1, f2;
	logic [PB-1:0]        v1, v2;
	logic                 en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= OP_ERODE;
			radius_q  <= 2'd1;
			width_q   <= 11'd1024;
			height_q  <= 16'd1024;
			mask_q    <= '0;
			bg_q      <= 8'd0;
			fg_q      <= 8'd1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OP_MODE:    op_mode_q <= bmw_op_t'(cfg_wr_data[1:0]);
				CFG_RADIUS:     radius_q  <= cfg_wr_data[RAD_BITS-1:0];
				CFG_WIDTH:      width_q   <= cfg_wr_data[10:0];
				CFG_HEIGHT:     height_q  <= cfg_wr_data[15:0];
				CFG_MASK:       mask_q    <= cfg_wr_data[MASK_BITS-1:0];
				CFG_BACKGROUND: bg_q      <= cfg_wr_data[7:0];
				CFG_FOREGROUND: fg_q      <= cfg_wr_data[7:0];
				default: ;
			endcase
		end
	end

	// geometry and element derived from the registers
	always_comb begin
		logic [5:0] mi;
		mi    = '0;
		rad_c = (int'(radius_q) > RAD) ? RAD_BITS'(RAD) : radius_q;
		if (width_q == '0) begin
			w_c = (CB+1)'(1);
		end else if (int'(width_q) > MAX_WIDTH) begin
			w_c = (CB+1)'(MAX_WIDTH);
		end else begin
			w_c = (CB+1)'(width_q);
		end
		h_c   = (height_q == '0) ? 16'd1 : height_q;
		d_c   = DB'(rad_c) * DB'(w_c) + DB'(rad_c);
		err_c = (2 * int'(rad_c) + 1 > int'(w_c)) || (2 * int'(rad_c) + 1 > int'(h_c));
		two_c = (op_mode_q == OP_OPENING) || (op_mode_q == OP_CLOSING);
		for (int j = 0; j < N; j++) begin
			for (int k = 0; k < N; k++) begin
				emask_c[j*N+k] = 1'b0;
				if (j <= 2 * int'(rad_c) && k <= 2 * int'(rad_c)) begin
					mi = 6'((int'(rad_c) - j + MASK_RAD) * MASK_SIDE
						+ (int'(rad_c) - k + MASK_RAD));
					emask_c[j*N+k] = mask_q[mi];
				end
			end
		end
		bg_c = PB'(bg_q);
		fg_c = PB'(fg_q);
		mode1.dilate = (op_mode_q == OP_DILATE) || (op_mode_q == OP_CLOSING);
		mode1.err    = err_c;
		mode1.rad    = rad_c;
		mode2.dilate = (op_mode_q == OP_OPENING);
		mode2.err    = err_c;
		mode2.rad    = rad_c;
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	bmw_stage #(
		.RAD        (RAD),
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.POS_BITS   (POS_BITS)
	) u_pass1 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (s_tvalid),
		.in_val    (s_tuser[0] ? bg_c : s_tdata[PB-1:0]),
		.in_start  (s_tuser[1]),
		.mode      (mode1),
		.w_eff     (w_c),
		.h_eff     (h_c),
		.win_delay (d_c),
		.bg        (bg_c),
		.fg        (fg_c),
		.emask     (emask_c),
		.out_flags (f1),
		.out_val   (v1)
	);

	bmw_stage #(
		.RAD        (RAD),
		.MAX_WIDTH  (MAX_WIDTH),
		.PIXEL_BITS (PIXEL_BITS),
		.POS_BITS   (POS_BITS)
	) u_pass2 (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (f1.vld),
		.in_val    (v1),
		.in_start  (f1.first),
		.mode      (mode2),
		.w_eff     (w_c),
		.h_eff     (h_c),
		.win_delay (d_c),
		.bg        (bg_c),
		.fg        (fg_c),
		.emask     (emask_c),
		.out_flags (f2),
		.out_val   (v2)
	);

	assign m_tvalid   = two_c ? (f2.vld && f2.inframe) : (f1.vld && f1.inframe);
	assign m_tdata    = TDW'(two_c ? v2 : v1);
	assign m_tlast    = two_c ? f2.last : f1.last;
	assign m_tuser[0] = err_c;
endmodule

FILE: tb/tb_binary_morphology_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_binary_morphology_window_core
// Self-checking bench for the streaming erode / dilate / open / close core.
// Frames of raster pixels go in under bursty valid and random output stalls;
// an item-by-item predictor of both window passes builds the expected pixels,
// and every output transaction is checked in order against them.
// ----------------------------------------------------------------------------
module tb_binary_morphology_window_core;
	import bmw_pkg::*;

	localparam int RING       = 8 * 1024;
	localparam int CYCLE_CAP  = 1500000;
	localparam int ITEM_GOAL  = 950;

	typedef struct {
		logic [7:0] pix;
		logic       flush;
		logic       fstart;
	} pixel_item_t;

	typedef struct {
		logic [7:0] pix;
		logic       last;
		logic       err;
	} out_pixel_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [48:0] cfg_wr_data;

	binary_morphology_window_core u_top (.*);

	// shadow configuration
	bmw_op_t     sh_op;
	int          sh_rad, sh_w, sh_h;
	logic [48:0] sh_mask;
	logic [7:0]  sh_bg, sh_fg;

	// predictor state
	logic [7:0]      line_ring [2][RING];
	longint unsigned raster_pos;

	pixel_item_t pixel_q[$];
	out_pixel_t  result_q[$];
	pixel_item_t held_item;
	int          burst_left, gap_left, stall_mode;
	int          n_errors, n_cycles, n_items;

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	function automatic logic [7:0] window_value(int s, bit dil, longint unsigned c);
		longint unsigned cy, cx;
		longint          ny, nx;
		logic [7:0]      v, nv;
		cy = c / sh_w;
		cx = c % sh_w;
		v = line_ring[s][c % RING];
		if (dil ? (v != sh_bg) : (v == sh_bg))
			return v;
		for (int dy = -sh_rad; dy <= sh_rad; dy++) begin
			for (int dx = -sh_rad; dx <= sh_rad; dx++) begin
				ny = longint'(cy) + dy;
				nx = longint'(cx) + dx;
				if (!sh_mask[(dy + 3) * 7 + dx + 3])
					continue;
				if (ny < 0 || nx < 0 || ny >= sh_h || nx >= sh_w)
					continue;
				nv = line_ring[s][(ny * sh_w + nx) % RING];
				if (dil && nv != sh_bg)
					return sh_fg;
				if (!dil && nv == sh_bg)
					return sh_bg;
			end
		end
		return v;
	endfunction

	task automatic predict_pixel(pixel_item_t it);
		longint unsigned d, total, pos, c1, c2;
		bit              err, two;
		logic [7:0]      r1, r2;
		d = sh_rad * sh_w + sh_rad;
		total = sh_w * sh_h;
		err = (2 * sh_rad + 1 > sh_w) || (2 * sh_rad + 1 > sh_h);
		two = (sh_op == OP_OPENING || sh_op == OP_CLOSING);
		r1 = sh_bg;
		if (it.fstart)
			raster_pos = 0;
		pos = raster_pos;
		line_ring[0][pos % RING] = it.flush ? sh_bg : it.pix;
		raster_pos++;
		if (pos < d)
			return;
		c1 = pos - d;
		if (c1 < total)
			r1 = err ? line_ring[0][c1 % RING]
				: window_value(0, sh_op == OP_DILATE || sh_op == OP_CLOSING, c1);
		if (!two) begin
			if (c1 < total)
				result_q.push_back('{r1, c1 == total - 1, err});
			return;
		end
		line_ring[1][c1 % RING] = (c1 < total) ? r1 : sh_bg;
		if (c1 < d)
			return;
		c2 = c1 - d;
		if (c2 >= total)
			return;
		r2 = err ? line_ring[1][c2 % RING] : window_value(1, sh_op == OP_OPENING, c2);
		result_q.push_back('{r2, c2 == total - 1, err});
	endtask

	// driver: bursts of random length separated by random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_pixel(held_item);
			if (!s_tvalid || s_tready) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					s_tvalid <= 1'b0;
				end else if (pixel_q.size() > 0) begin
					held_item = pixel_q.pop_front();
					s_tdata <= held_item.pix;
					s_tuser <= {held_item.fstart, held_item.flush};
					s_tvalid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 40);
						gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor with its own stall pattern
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			stall_mode <= 0;
			n_cycles <= 0;
		end else begin
			n_cycles <= n_cycles + 1;
			if (n_cycles >= CYCLE_CAP) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
			if (n_cycles % 128 == 0)
				stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0, 1: m_tready <= 1'b1;
				2: m_tready <= $urandom_range(0, 1);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
			if (m_tvalid && m_tready) begin
				if (result_q.size() == 0) begin
					$display("%0t: unexpected result pix=%0d last=%0b err=%0b", $time,
						m_tdata, m_tlast, m_tuser);
					n_errors++;
				end else begin
					out_pixel_t e;
					e = result_q.pop_front();
					if (m_tdata !== e.pix) begin
						$display("%0t: pixel_out expected %0d actual %0d", $time, e.pix, m_tdata);
						n_errors++;
					end
					if (m_tlast !== e.last) begin
						$display("%0t: frame_last expected %0b actual %0b", $time, e.last, m_tlast);
						n_errors++;
					end
					if (m_tuser[0] !== e.err) begin
						$display("%0t: size_error expected %0b actual %0b", $time, e.err,
							m_tuser[0]);
						n_errors++;
					end
				end
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [48:0] val);
		@(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wr_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic setup(bmw_op_t op, int rad, int w, int h, logic [48:0] mask,
			logic [7:0] bg, logic [7:0] fg);
		sh_op = op;
		sh_rad = rad;
		sh_w = w;
		sh_h = h;
		sh_mask = mask;
		sh_bg = bg;
		sh_fg = fg;
		write_reg(CFG_OP_MODE, 49'(op));
		write_reg(CFG_RADIUS, 49'(rad));
		write_reg(CFG_WIDTH, 49'(w));
		write_reg(CFG_HEIGHT, 49'(h));
		write_reg(CFG_MASK, mask);
		write_reg(CFG_BACKGROUND, 49'(bg));
		write_reg(CFG_FOREGROUND, 49'(fg));
	endtask

	// one frame; 0 < cut < w*h stops it early (no drain), so the next frame start drops the tail
	task automatic add_frame(int cut, bit noisy);
		int          total, n, drain;
		pixel_item_t it;
		total = sh_w * sh_h;
		n = (cut > 0 && cut < total) ? cut : total;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 3))
				0, 3: it.pix = sh_bg;
				1: it.pix = sh_fg;
				default: it.pix = $urandom_range(0, 255);
			endcase
			it.flush = noisy && ($urandom_range(0, 15) == 0);
			it.fstart = (i == 0);
			pixel_q.push_back(it);
		end
		n_items += n;
		if (cut > 0 && cut < total)
			return;
		drain = (sh_rad * sh_w + sh_rad) * ((sh_op == OP_OPENING || sh_op == OP_CLOSING) ? 2 : 1);
		drain += noisy ? $urandom_range(0, 3) : 0;
		for (int i = 0; i < drain; i++) begin
			it.pix = $urandom_range(0, 255);
			it.flush = (i < drain - 3) ? 1'b1 : $urandom_range(0, 1);
			it.fstart = 1'b0;
			pixel_q.push_back(it);
		end
		n_items += drain;
	endtask

	task automatic drain_all();
		while (pixel_q.size() > 0 || s_tvalid)
			@(posedge clk);
		while (result_q.size() > 0)
			@(posedge clk);
		// let ignored items leave the pipeline before touching registers
		repeat (20) @(posedge clk);
	endtask

	initial begin
		bmw_op_t op;
		int      w, h;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_wr_data = '0;
		n_errors = 0;
		n_items = 0;
		raster_pos = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: each mode, window larger than image, extremes of geometry
		setup(OP_ERODE, 1, 5, 4, {49{1'b1}}, 8'd0, 8'd1);
		add_frame(0, 0);
		drain_all();
		setup(OP_DILATE, 0, 1, 1, {49{1'b1}}, 8'd0, 8'd255);
		add_frame(0, 0);
		drain_all();
		setup(OP_DILATE, 3, 3, 3, {49{1'b1}}, 8'd0, 8'd255);
		add_frame(0, 1);
		drain_all();
		setup(OP_OPENING, 2, 8, 6, {$urandom, $urandom}, 8'd255, 8'd0);
		add_frame(0, 1);
		drain_all();
		setup(OP_CLOSING, 3, 7, 7, {49{1'b1}}, 8'd170, 8'd85);
		add_frame(0, 1);
		drain_all();
		setup(OP_ERODE, 0, 1024, 1, 49'd0, 8'd0, 8'd1);
		add_frame(20, 1);
		add_frame(12, 1);
		drain_all();
		setup(OP_DILATE, 1, 2, 65535, {49{1'b1}}, 8'd0, 8'd1);
		add_frame(24, 1);
		drain_all();

		while (n_items < ITEM_GOAL) begin
			op = bmw_op_t'($urandom_range(0, 3));
			w = $urandom_range(1, 12);
			h = $urandom_range(1, 10);
			setup(op, $urandom_range(0, 3), w, h, {$urandom, $urandom},
				($urandom_range(0, 1) ? 8'd0 : 8'($urandom)), 8'($urandom));
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(0, 5) == 0)
					add_frame($urandom_range(1, w * h), 1);
				else
					add_frame(0, 1);
			end
			drain_all();
		end

		if (n_errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
